[rtl/slc_pkg.sv]
// ----------------------------------------------------------------------------
// slc_pkg: shared types and constants for the striped LRU cache
// Field structs, action codes, sequencer states, hash constants.
// ----------------------------------------------------------------------------
`default_nettype none
package slc_pkg;
    localparam int NUM_SETS = 16;
    localparam int WAYS = 8;
    localparam int PAYLOAD_WIDTH = 64;
    localparam int SET_W = $clog2(NUM_SETS);
    localparam int WAY_W = $clog2(WAYS);
    localparam int FILL_W = $clog2(WAYS + 1);
    localparam int ENTRIES = NUM_SETS * WAYS;
    localparam int ADDR_W = SET_W + WAY_W;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int TIME_W = 48;
    localparam int TAG_W = 64 + TIME_W;

    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

    localparam logic [0:0] CFG_WAYS = 1'b0;
    localparam logic [0:0] CFG_TTL  = 1'b1;

    typedef enum logic [1:0] {
        ACT_GET = 2'd0,
        ACT_PUT = 2'd1,
        ACT_INV = 2'd2,
        ACT_NOP = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] key;
        logic [63:0] data_in;
        logic [47:0] now_ms;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic        expired;
        logic [63:0] data_out;
        logic [7:0]  occupancy;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_SCAN,
        ST_DECIDE,
        ST_EVICT,
        ST_WRITE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic          start;
        logic [63:0]   key;
    } hash_req_t;

    typedef struct packed {
        logic             done;
        logic [SET_W-1:0] set_idx;
    } hash_rsp_t;
endpackage
`default_nettype wire

[rtl/slc_ram.sv]
// ----------------------------------------------------------------------------
// slc_ram: generic simple dual-port RAM
// One write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module slc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

[rtl/slc_hash.sv]
// ----------------------------------------------------------------------------
// slc_hash: set index from the splitmix64 finalizer
// One 32x32 multiplier, shared over partial products, under a step counter.
// ----------------------------------------------------------------------------
`default_nettype none
module slc_hash
    import slc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire hash_req_t req,
    output hash_rsp_t      rsp
);
    // Steps 0..2: x1*C1 partials, 3: xor-shift, 4..6: x2*C2 partials, 7: out.
    // Only the low 64 bits of each product matter: lo*lo + (lo*hi + hi*lo)<<32.
    logic [2:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] op_a, op_b;
    logic [63:0] prod;
    logic [63:0] cst;
    logic [63:0] fin;

    assign cst  = (step_reg < 3'd4) ? MIX_C1 : MIX_C2;
    assign prod = op_a * op_b;
    assign fin  = acc_reg ^ (acc_reg >> 31);

    always_comb begin
        case (step_reg)
            3'd0, 3'd4: begin op_a = x_reg[31:0];  op_b = cst[31:0];  end
            3'd1, 3'd5: begin op_a = x_reg[31:0];  op_b = cst[63:32]; end
            3'd2, 3'd6: begin op_a = x_reg[63:32]; op_b = cst[31:0];  end
            default:    begin op_a = '0;           op_b = '0;         end
        endcase
    end

    always_comb begin
        step_next = step_reg;
        busy_next = busy_reg;
        x_next    = x_reg;
        acc_next  = acc_reg;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = 3'd0;
            x_next    = req.key ^ (req.key >> 30);
        end else if (busy_reg) begin
            step_next = step_reg + 3'd1;
            case (step_reg)
                3'd0, 3'd4: acc_next = prod;
                3'd1, 3'd2, 3'd5, 3'd6: acc_next = acc_reg + {prod[31:0], 32'd0};
                3'd3: x_next = acc_reg ^ (acc_reg >> 27);
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
        x_reg   <= x_next;
        acc_reg <= acc_next;
    end

    assign rsp.done    = busy_reg && (step_reg == 3'd7);
    assign rsp.set_idx = fin[SET_W-1:0];
endmodule
`default_nettype wire

[rtl/striped_lru_cache_with_ttl.sv]
// ----------------------------------------------------------------------------
// striped_lru_cache_with_ttl: 16-set, 8-way LRU cache with age limit
// Sequenced lookup over one set, tags and payloads in RAM, ranks in flops.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  s_       | in        | s_valid / s_ready  | req_t: action,key,data_in,now
//  m_       | out       | m_valid / m_ready  | rsp_t: hit,expired,data,occ
//  cfg      | in        | cfg_we             | cfg_index, cfg_wdata
//
// From acceptance to m_valid a request passes through the hash (the shared
// hash multiplier), the tag scan (one tag RAM port, one read per way),
// then read, decide and write. A hit ends the scan early; an eviction
// adds the evict state and a second decide.
// s_ready is high only in IDLE; the result sits in a register until m_ready.
// Reset is synchronous on aresetn and clears valid bits, ranks and fill
// counts; the tag and payload RAMs need no clearing.
//
`default_nettype none
module striped_lru_cache_with_ttl
    import slc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire req_t        s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output rsp_t             m_data,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wdata
);
    state_t state_reg, state_next;

    // configuration
    logic [3:0]  ways_reg;
    logic [31:0] ttl_reg;
    logic [FILL_W-1:0] cap;
    always_comb begin
        if (ways_reg == 4'd0) cap = FILL_W'(1);
        else if (ways_reg > 4'(WAYS)) cap = FILL_W'(WAYS);
        else cap = FILL_W'(ways_reg);
    end

    // latched request
    req_t req_reg;

    // per-entry control in flops
    logic [WAYS-1:0]  valid_reg [NUM_SETS];
    logic [WAY_W-1:0] rank_reg  [NUM_SETS][WAYS];
    logic [FILL_W-1:0] fill_reg [NUM_SETS];
    logic [OCC_W-1:0] occ_reg;

    // hash unit
    hash_req_t hreq;
    hash_rsp_t hrsp;
    logic [SET_W-1:0] set_reg;

    assign hreq.start = (state_reg == ST_IDLE) && s_valid;
    assign hreq.key   = s_data.key;

    slc_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (hreq),
        .rsp     (hrsp)
    );

    // scan counters
    logic [WAY_W:0]   way_cnt_reg;   // way whose tag read was issued
    logic [WAY_W-1:0] found_way_reg;
    logic             found_reg;
    logic             chk_reg;       // a read is in flight to compare
    logic [WAY_W-1:0] chk_way_reg;

    // tag RAM: {stamp, key}
    logic             tag_we;
    logic [ADDR_W-1:0] tag_waddr, tag_raddr;
    logic [TAG_W-1:0] tag_wdata, tag_rdata;
    logic             pay_we;
    logic [ADDR_W-1:0] pay_raddr;
    logic [PAYLOAD_WIDTH-1:0] pay_rdata;

    slc_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tag (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    slc_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(ENTRIES)) u_pay (
        .aclk  (aclk),
        .we    (pay_we),
        .waddr (tag_waddr),
        .wdata (req_reg.data_in[PAYLOAD_WIDTH-1:0]),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    // Decision work: per-set views
    logic [WAYS-1:0]   cur_valid;
    logic [FILL_W-1:0] cur_fill;
    logic [WAY_W-1:0]  lru_way, free_way, victim_way, ins_way;
    logic              any_free;
    logic [47:0]       age;
    logic              is_expired;
    logic              need_evict;

    assign cur_valid = valid_reg[set_reg];
    assign cur_fill  = fill_reg[set_reg];
    assign age       = req_reg.now_ms - tag_rdata[TAG_W-1:64];
    assign is_expired = (ttl_reg != 32'd0) && (age > {16'd0, ttl_reg});

    always_comb begin
        lru_way  = '0;
        free_way = '0;
        any_free = 1'b0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (!cur_valid[i]) begin
                free_way = WAY_W'(i);
                any_free = 1'b1;
            end
        end
        for (int i = 0; i < WAYS; i++) begin
            if (cur_valid[i] && rank_reg[set_reg][i] == WAY_W'(cur_fill - FILL_W'(1))) begin
                lru_way = WAY_W'(i);
            end
        end
    end
    // ranks in a set are a dense permutation 0..fill-1, so LRU has rank fill-1

    logic evicted_reg;          // eviction done this request
    assign need_evict = (cur_fill >= cap) && !evicted_reg;

    // tag address: walks the ways during the scan, then stays on the found
    // way so the stamp is on tag_rdata through decide and write
    always_comb begin
        if (state_reg == ST_SCAN) tag_raddr = {set_reg, way_cnt_reg[WAY_W-1:0]};
        else tag_raddr = {set_reg, found_way_reg};
        pay_raddr = {set_reg, found_way_reg};
    end

    assign ins_way = free_way;
    assign victim_way = lru_way;

    always_comb begin
        tag_we    = 1'b0;
        pay_we    = 1'b0;
        tag_waddr = {set_reg, found_way_reg};
        tag_wdata = {req_reg.now_ms, req_reg.key};
        if (state_reg == ST_WRITE && req_reg.action == ACT_PUT) begin
            tag_we = 1'b1;
            pay_we = 1'b1;
            if (!found_reg) tag_waddr = {set_reg, ins_way};
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_HASH;
            ST_HASH:   if (hrsp.done) state_next = ST_SCAN;
            ST_SCAN: begin
                if (found_reg || (!chk_reg && way_cnt_reg == (WAY_W+1)'(WAYS)))
                    state_next = ST_READ;
            end
            ST_READ:   state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (req_reg.action == ACT_PUT && !found_reg && (need_evict || !any_free))
                    state_next = ST_EVICT;
                else
                    state_next = ST_WRITE;
            end
            ST_EVICT:  state_next = ST_DECIDE;
            ST_WRITE:  state_next = ST_RESP;
            ST_RESP:   if (m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        m_valid = (state_reg == ST_RESP);
    end

    rsp_t rsp_reg, rsp_next;
    assign m_data = rsp_reg;

    // result built from the lookup, latched in WRITE
    always_comb begin
        rsp_next = '0;
        rsp_next.occupancy = 8'(occ_reg);
        case (req_reg.action)
            ACT_GET: begin
                if (found_reg && is_expired) begin
                    rsp_next.expired   = 1'b1;
                    rsp_next.occupancy = 8'(occ_reg - 1'b1);
                end else if (found_reg) begin
                    rsp_next.hit      = 1'b1;
                    rsp_next.data_out = 64'(pay_rdata);
                end
            end
            ACT_PUT: begin
                rsp_next.hit = 1'b1;
                if (!found_reg) rsp_next.occupancy = 8'(occ_reg + 1'b1);
            end
            ACT_INV: begin
                if (found_reg) begin
                    rsp_next.hit       = 1'b1;
                    rsp_next.occupancy = 8'(occ_reg - 1'b1);
                end
            end
            default: ;
        endcase
    end

    // rank of the way being removed or promoted
    logic [WAY_W-1:0] tgt_rank;
    assign tgt_rank = rank_reg[set_reg][(state_reg == ST_EVICT) ? victim_way : found_way_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ways_reg  <= 4'd8;
            ttl_reg   <= '0;
            occ_reg   <= '0;
            for (int s = 0; s < NUM_SETS; s++) begin
                valid_reg[s] <= '0;
                fill_reg[s]  <= '0;
                for (int w = 0; w < WAYS; w++) rank_reg[s][w] <= '0;
            end
            chk_reg     <= 1'b0;
            found_reg   <= 1'b0;
            evicted_reg <= 1'b0;
            way_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_WAYS: ways_reg <= cfg_wdata[3:0];
                    CFG_TTL:  ttl_reg  <= cfg_wdata;
                    default:  ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    found_reg   <= 1'b0;
                    evicted_reg <= 1'b0;
                    chk_reg     <= 1'b0;
                    way_cnt_reg <= '0;
                end
                ST_SCAN: begin
                    // one tag read issued per cycle, compared the next
                    if (chk_reg && cur_valid[chk_way_reg]
                        && tag_rdata[63:0] == req_reg.key) begin
                        found_reg     <= 1'b1;
                        found_way_reg <= chk_way_reg;
                    end
                    if (way_cnt_reg != (WAY_W+1)'(WAYS)) begin
                        chk_reg     <= 1'b1;
                        chk_way_reg <= way_cnt_reg[WAY_W-1:0];
                        way_cnt_reg <= way_cnt_reg + 1'b1;
                    end else begin
                        chk_reg <= 1'b0;
                    end
                end
                ST_EVICT: begin
                    for (int i = 0; i < WAYS; i++)
                        if (cur_valid[i] && rank_reg[set_reg][i] > tgt_rank)
                            rank_reg[set_reg][i] <= rank_reg[set_reg][i] - 1'b1;
                    rank_reg[set_reg][victim_way]  <= '0;
                    valid_reg[set_reg][victim_way] <= 1'b0;
                    fill_reg[set_reg] <= cur_fill - 1'b1;
                    occ_reg <= occ_reg - 1'b1;
                    evicted_reg <= 1'b1;
                end
                ST_WRITE: begin
                    rsp_reg <= rsp_next;
                    case (req_reg.action)
                        ACT_GET: begin
                            if (found_reg && is_expired) begin
                                for (int i = 0; i < WAYS; i++)
                                    if (cur_valid[i] && rank_reg[set_reg][i] > tgt_rank)
                                        rank_reg[set_reg][i] <= rank_reg[set_reg][i] - 1'b1;
                                rank_reg[set_reg][found_way_reg]  <= '0;
                                valid_reg[set_reg][found_way_reg] <= 1'b0;
                                fill_reg[set_reg] <= cur_fill - 1'b1;
                                occ_reg <= occ_reg - 1'b1;
                            end else if (found_reg) begin
                                for (int i = 0; i < WAYS; i++)
                                    if (cur_valid[i] && rank_reg[set_reg][i] < tgt_rank)
                                        rank_reg[set_reg][i] <= rank_reg[set_reg][i] + 1'b1;
                                rank_reg[set_reg][found_way_reg] <= '0;
                            end
                        end
                        ACT_PUT: begin
                            if (found_reg) begin
                                for (int i = 0; i < WAYS; i++)
                                    if (cur_valid[i] && rank_reg[set_reg][i] < tgt_rank)
                                        rank_reg[set_reg][i] <= rank_reg[set_reg][i] + 1'b1;
                                rank_reg[set_reg][found_way_reg] <= '0;
                            end else begin
                                for (int i = 0; i < WAYS; i++)
                                    if (cur_valid[i])
                                        rank_reg[set_reg][i] <= rank_reg[set_reg][i] + 1'b1;
                                rank_reg[set_reg][ins_way]  <= '0;
                                valid_reg[set_reg][ins_way] <= 1'b1;
                                fill_reg[set_reg] <= cur_fill + 1'b1;
                                occ_reg <= occ_reg + 1'b1;
                            end
                        end
                        ACT_INV: begin
                            if (found_reg) begin
                                for (int i = 0; i < WAYS; i++)
                                    if (cur_valid[i] && rank_reg[set_reg][i] > tgt_rank)
                                        rank_reg[set_reg][i] <= rank_reg[set_reg][i] - 1'b1;
                                rank_reg[set_reg][found_way_reg]  <= '0;
                                valid_reg[set_reg][found_way_reg] <= 1'b0;
                                fill_reg[set_reg] <= cur_fill - 1'b1;
                                occ_reg <= occ_reg - 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        if (state_reg == ST_IDLE && s_valid) req_reg <= s_data;
        if (hrsp.done) set_reg <= hrsp.set_idx;
    end
    // ST_READ reads the found way's tag (stamp) and payload; both addresses
    // hold on the found way until the write.

`ifndef SYNTH
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input and result sides both open");
    a_occ_max: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(ENTRIES)) else $error("occupancy above capacity");
    a_resp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data)) else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire
